>>> rtl/tilemap_zero_run_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zero-run tile picture decoder
// Concurrent assertion wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_ZERO_RUN_DECODER_UNIT_DEFINES_SVH
`define TILEMAP_ZERO_RUN_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TZRD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tzrd assertion failed");
`define TZRD_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define TZRD_ASSERT(lbl, clk, rst_n, prop)
`define TZRD_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

>>> rtl/tzrd_pkg.sv
// ----------------------------------------------------------------------------
// Zero-run tile picture decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package tzrd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CntW     = 10;
  localparam int unsigned PosW     = 11;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CoordW   = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_LAYER    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CfgDataW-1:0] origin_x;
    logic signed [CfgDataW-1:0] origin_y;
    logic [CntW-1:0]            width_tiles;
    logic [CntW-1:0]            height_tiles;
    logic [1:0]                 layer_select;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] next_word;
    logic             start_req;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  tile_value;
    logic [CoordW-1:0] tile_row;
    logic [CoordW-1:0] tile_col;
    logic              write_enable;
    logic              word_taken;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

>>> rtl/tzrd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds origin, picture size and layer, written through a plain write port.
// ----------------------------------------------------------------------------
module tzrd_cfg_regs
  import tzrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: cfg_q.origin_x     <= cfg_wdata_i;
        CFG_ORIGIN_Y: cfg_q.origin_y     <= cfg_wdata_i;
        CFG_WIDTH:    cfg_q.width_tiles  <= cfg_wdata_i;
        CFG_HEIGHT:   cfg_q.height_tiles <= cfg_wdata_i;
        CFG_LAYER:    cfg_q.layer_select <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/tzrd_walker.sv
// ----------------------------------------------------------------------------
// Picture walker
// Run and position counters with the one-position decode and clipping step.
// ----------------------------------------------------------------------------
`include "tilemap_zero_run_decoder_unit_defines.svh"

module tzrd_walker
  import tzrd_pkg::*;
#(
  parameter int unsigned VISIBLE_ROWS = 20,
  parameter int unsigned VISIBLE_COLS = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_en_i,
  input  in_item_t  item_i,
  output step_res_t res_o
);

  localparam logic signed [PosW-1:0] RowsS  = PosW'(VISIBLE_ROWS);
  localparam logic signed [PosW-1:0] ColsS  = PosW'(VISIBLE_COLS);
  localparam logic signed [PosW-1:0] ColMax = PosW'(1023);

  logic [CntW-1:0]        run_rem_q, run_rem_d, run_e, run_n;
  logic [CntW-1:0]        row_cnt_q, row_cnt_d, rc_e;
  logic [CntW-1:0]        col_cnt_q, col_cnt_d, cc_e;
  logic signed [PosW-1:0] row_pos_q, row_pos_d, rp_e, rp_inc;
  logic signed [PosW-1:0] col_pos_q, col_pos_d, cp_e;
  logic signed [PosW-1:0] ox_ext, oy_ext, first_col;
  logic                   active_q, active_d, act_e;
  logic                   taken, literal, we, col_end, row_done;

  always_comb begin
    ox_ext = {cfg_i.origin_x[CfgDataW-1], cfg_i.origin_x};
    oy_ext = {cfg_i.origin_y[CfgDataW-1], cfg_i.origin_y};

    if (item_i.start_req) begin
      run_e = '0;
      rc_e  = '0;
      cc_e  = '0;
      rp_e  = oy_ext;
      cp_e  = ox_ext;
      act_e = (cfg_i.width_tiles != '0) && (cfg_i.height_tiles != '0) && (oy_ext < RowsS);
    end else begin
      run_e = run_rem_q;
      rc_e  = row_cnt_q;
      cc_e  = col_cnt_q;
      rp_e  = row_pos_q;
      cp_e  = col_pos_q;
      act_e = active_q;
    end

    taken   = (run_e == '0);
    literal = (item_i.next_word[WordW-1:WordW-4] != '0);
    if (taken) begin
      run_n = literal ? '0 : item_i.next_word[CntW-1:0];
    end else begin
      run_n = run_e;
    end
    if (run_n != '0) begin
      run_n = run_n - CntW'(1);
    end

    first_col = (cfg_i.layer_select == 2'd0) ? PosW'(1) : PosW'(0);
    we = (cp_e >= first_col) && (cp_e < ColsS) && !rp_e[PosW-1] && (rp_e < RowsS);

    rp_inc   = rp_e + PosW'(1);
    col_end  = ({1'b0, cc_e} + PosW'(1)) >= {1'b0, cfg_i.width_tiles};
    row_done = (({1'b0, rc_e} + PosW'(1)) >= {1'b0, cfg_i.height_tiles}) || (rp_inc >= RowsS);

    res_o.valid             = act_e;
    res_o.item.tile_value   = (taken && literal) ? item_i.next_word : '0;
    res_o.item.tile_row     = we ? rp_e[CoordW-1:0] : '0;
    res_o.item.tile_col     = we ? cp_e[CoordW-1:0] : '0;
    res_o.item.write_enable = we;
    res_o.item.word_taken   = taken;
    res_o.item.last         = col_end && row_done;

    run_rem_d = run_e;
    row_cnt_d = rc_e;
    col_cnt_d = cc_e;
    row_pos_d = rp_e;
    col_pos_d = cp_e;
    active_d  = act_e;
    if (act_e) begin
      run_rem_d = run_n;
      if (col_end) begin
        col_cnt_d = '0;
        col_pos_d = ox_ext;
        row_pos_d = rp_inc;
        if (row_done) begin
          active_d  = 1'b0;
          row_cnt_d = '0;
        end else begin
          row_cnt_d = rc_e + CntW'(1);
        end
      end else begin
        col_cnt_d = cc_e + CntW'(1);
        if (cp_e < ColMax) begin
          col_pos_d = cp_e + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_rem_q <= '0;
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      row_pos_q <= '0;
      col_pos_q <= '0;
      active_q  <= 1'b0;
    end else if (step_en_i) begin
      run_rem_q <= run_rem_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
      active_q  <= active_d;
    end
  end

  `TZRD_ASSERT(a_last_goes_idle, clk_i, rst_ni, step_en_i && res_o.valid && res_o.item.last |=> !active_q)
  `TZRD_ASSERT(a_idle_row_in_window, clk_i, rst_ni, active_q |-> row_pos_q < RowsS)
  `TZRD_ASSERT(a_run_word_skipped, clk_i, rst_ni, step_en_i && res_o.valid && !res_o.item.word_taken |-> run_rem_q != '0)

endmodule

>>> rtl/tilemap_zero_run_decoder_unit.sv
// ----------------------------------------------------------------------------
// Zero-run tile picture decoder
// Expands a zero-run-coded tile stream into clipped tile writes, one result
// transaction per picture position.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                           Width
// in       input      in_valid_i/in_ready_o/in_item_i    17
// out      output     out_valid_o/out_ready_i/out_item_o 29
// cfg      input      cfg_we_i/cfg_idx_i/cfg_wdata_i     3 + 10
//
// One input transaction is accepted per cycle unless the output stalls; its
// result passes through the input register and then the output register.
// An input transaction that falls outside an active picture yields no result.
// A stalled output holds the result register and the input register in turn.
// Reset clears the configuration, the counters and both stage valid flags.
// ----------------------------------------------------------------------------
`include "tilemap_zero_run_decoder_unit_defines.svh"

module tilemap_zero_run_decoder_unit
  import tzrd_pkg::*;
#(
  parameter int unsigned VISIBLE_ROWS = 20,
  parameter int unsigned VISIBLE_COLS = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  step_res_t res;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      out_free, step_en;

  tzrd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tzrd_walker #(
    .VISIBLE_ROWS (VISIBLE_ROWS),
    .VISIBLE_COLS (VISIBLE_COLS)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (step_en),
    .item_i    (s1_item_q),
    .res_o     (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step_en    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (out_free) begin
      out_valid_d = step_en && res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (step_en && res.valid) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `TZRD_ASSERT(a_write_in_window, clk_i, rst_ni, out_valid_o && out_item_o.write_enable |-> (out_item_o.tile_row < VISIBLE_ROWS) && (out_item_o.tile_col < VISIBLE_COLS))
  `TZRD_ASSERT(a_clipped_coords_zero, clk_i, rst_ni, out_valid_o && !out_item_o.write_enable |-> (out_item_o.tile_row == '0) && (out_item_o.tile_col == '0))
  `TZRD_ASSERT_MSG(a_run_value_zero, clk_i, rst_ni, out_valid_o && !out_item_o.word_taken |-> out_item_o.tile_value == '0, "tile inside a run is not zero")

endmodule
